// File: rtl/hrlp_pkg.sv
// Shared types, codes and character tables for the HTTP request line parser.
// No dependencies; imported by every module of the block.
package hrlp_pkg;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_PATH    = 3'd1,
    PH_QUERY   = 3'd2,
    PH_VERSION = 3'd3,
    PH_DONE    = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PATH     = 3'd1,
    EV_KEY      = 3'd2,
    EV_VALUE    = 3'd3,
    EV_NEW_PAIR = 3'd4,
    EV_COMPLETE = 3'd5,
    EV_ERROR    = 3'd6
  } event_t;

  localparam logic [2:0] METHOD_UNKNOWN = 3'd0;
  localparam logic [2:0] METHOD_GET     = 3'd1;
  localparam logic [2:0] METHOD_PUT     = 3'd2;
  localparam logic [2:0] METHOD_POST    = 3'd3;
  localparam logic [2:0] METHOD_PATCH   = 3'd4;
  localparam logic [2:0] METHOD_DELETE  = 3'd5;

  localparam int TDATA_W = 48;

  typedef struct packed {
    logic        [2:0] event_res;
    logic        [7:0] data;
    logic        [2:0] method;
    logic        [7:0] path_position;
    logic        [4:0] query_index;
    logic signed [8:0] version_major;
    logic signed [8:0] version_minor;
  } result_t;

  function automatic logic [2:0] word_len(input logic [2:0] guess);
    logic [2:0] len;
    case (guess)
      METHOD_GET:    len = 3'd4;
      METHOD_PUT:    len = 3'd4;
      METHOD_POST:   len = 3'd5;
      METHOD_PATCH:  len = 3'd6;
      METHOD_DELETE: len = 3'd7;
      default:       len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] word_char(input logic [2:0] guess, input logic [2:0] idx);
    logic [55:0] word;
    case (guess)
      METHOD_GET:    word = {8'h00, 8'h00, 8'h00, " TEG"};
      METHOD_PUT:    word = {8'h00, 8'h00, 8'h00, " TUP"};
      METHOD_POST:   word = {8'h00, 8'h00, " TSOP"};
      METHOD_PATCH:  word = {8'h00, " HCTAP"};
      METHOD_DELETE: word = " ETELED";
      default:       word = '0;
    endcase
    return word[idx*8 +: 8];
  endfunction

  function automatic logic [7:0] version_char(input logic [2:0] idx);
    logic [55:0] word;
    word = ".?/PTTH";
    return (idx == 3'd7) ? 8'h00 : word[idx*8 +: 8];
  endfunction

  function automatic logic [7:0] hex_value(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (c >= 8'h61 && c <= 8'h7A) begin
      c = c - 8'd32;
    end
    return (c >= 8'h41) ? c - 8'd55 : c - 8'd48;
  endfunction

  function automatic logic path_char_ok(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || b == 8'h2F || b == 8'h2D ||
           b == 8'h2E || b == 8'h5F || b == 8'h7E;
  endfunction

endpackage

// File: rtl/hrlp_core.sv
// Parser state registers and the per-byte next-state and result logic.
// Depends on hrlp_pkg.
module hrlp_core
  import hrlp_pkg::*;
#(
  parameter int MAX_PATH    = 256,
  parameter int MAX_QUERIES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_value,
  input  logic       restart,
  output result_t    result
);

  localparam int PW = $clog2(MAX_PATH + 1);
  localparam int QW = $clog2(MAX_QUERIES + 1);

  phase_t          phase, phase_next;
  logic [2:0]      sub_count, sub_count_next;
  logic [2:0]      method_guess, method_guess_next;
  logic [PW-1:0]   store_position, store_position_next;
  logic [QW-1:0]   pair_count, pair_count_next;
  logic            in_key, in_key_next;
  logic [1:0]      escape_stage, escape_stage_next;
  logic [7:0]      high_nibble, high_nibble_next;
  logic [8:0]      major_digit, major_digit_next;

  always_comb begin
    phase_t        cp;
    logic [2:0]    cs;
    logic [2:0]    cg;
    logic [PW-1:0] cpos;
    logic [QW-1:0] cpair;
    logic          ckey;
    logic [1:0]    cesc;
    logic [7:0]    chn;
    logic [8:0]    cmaj;
    logic          err;
    logic          emit;
    logic          q;
    logic [7:0]    dat;
    logic [2:0]    g;

    if (restart) begin
      cp = PH_METHOD; cs = '0; cg = METHOD_UNKNOWN; cpos = '0; cpair = '0;
      ckey = 1'b1; cesc = '0; chn = '0; cmaj = '0;
    end else begin
      cp = phase; cs = sub_count; cg = method_guess; cpos = store_position;
      cpair = pair_count; ckey = in_key; cesc = escape_stage; chn = high_nibble;
      cmaj = major_digit;
    end

    phase_next = cp; sub_count_next = cs; method_guess_next = cg;
    store_position_next = cpos; pair_count_next = cpair; in_key_next = ckey;
    escape_stage_next = cesc; high_nibble_next = chn; major_digit_next = cmaj;
    result = '0;
    err = 1'b0; emit = 1'b0; dat = '0; g = cg;
    q = (cp == PH_QUERY);

    case (cp)
      PH_METHOD: begin
        if (cs == 3'd0) begin
          case (byte_value)
            "G":     g = METHOD_GET;
            "P":     g = METHOD_PUT;
            "D":     g = METHOD_DELETE;
            default: err = 1'b1;
          endcase
        end else if (cs == 3'd1 && cg >= METHOD_PUT && cg <= METHOD_PATCH) begin
          case (byte_value)
            "U":     g = METHOD_PUT;
            "O":     g = METHOD_POST;
            "A":     g = METHOD_PATCH;
            default: err = 1'b1;
          endcase
        end else if (cs >= word_len(cg) || byte_value != word_char(cg, cs)) begin
          err = 1'b1;
        end
        if (err) begin
          method_guess_next = METHOD_UNKNOWN;
        end else begin
          method_guess_next = g;
          if (cs + 3'd1 == word_len(g)) begin
            phase_next     = PH_PATH;
            sub_count_next = '0;
          end else begin
            sub_count_next = cs + 3'd1;
          end
        end
      end
      PH_PATH, PH_QUERY: begin
        if (cesc == 2'd1) begin
          high_nibble_next  = hex_value(byte_value);
          escape_stage_next = 2'd2;
        end else if (cesc == 2'd2) begin
          escape_stage_next = 2'd0;
          dat  = {chn[3:0], 4'h0} | hex_value(byte_value);
          emit = 1'b1;
        end else if (cpos >= (q ? PW'(MAX_PATH) : PW'(MAX_PATH - 1))) begin
          err = 1'b1;
        end else if (byte_value == " ") begin
          phase_next     = PH_VERSION;
          sub_count_next = '0;
        end else if (byte_value == 8'h00) begin
          err = 1'b1;
        end else if (!q && byte_value == "?") begin
          phase_next          = PH_QUERY;
          store_position_next = cpos + 1'b1;
          pair_count_next     = QW'(1);
          in_key_next         = 1'b1;
          result.event_res    = EV_NEW_PAIR;
        end else if (q && byte_value == "=" && ckey) begin
          in_key_next         = 1'b0;
          store_position_next = cpos + 1'b1;
        end else if (q && byte_value == "&") begin
          if (cpair >= QW'(MAX_QUERIES)) begin
            err = 1'b1;
          end else begin
            pair_count_next     = cpair + 1'b1;
            in_key_next         = 1'b1;
            store_position_next = cpos + 1'b1;
            result.event_res    = EV_NEW_PAIR;
            result.query_index  = 5'(cpair);
          end
        end else if (byte_value == "%") begin
          escape_stage_next = 2'd1;
        end else if (!q && !path_char_ok(byte_value)) begin
          err = 1'b1;
        end else begin
          dat  = byte_value;
          emit = 1'b1;
        end
        if (emit) begin
          result.event_res     = q ? (ckey ? EV_KEY : EV_VALUE) : EV_PATH;
          result.data          = dat;
          result.path_position = 8'(cpos);
          result.query_index   = q ? 5'(cpair - 1'b1) : 5'd0;
          store_position_next  = cpos + 1'b1;
        end
      end
      PH_VERSION: begin
        if (cs == 3'd5) begin
          major_digit_next = {1'b0, byte_value} - 9'd48;
          sub_count_next   = cs + 3'd1;
        end else if (cs == 3'd7) begin
          result.event_res     = EV_COMPLETE;
          result.version_major = cmaj;
          result.version_minor = {1'b0, byte_value} - 9'd48;
          phase_next           = PH_DONE;
        end else if (byte_value != version_char(cs)) begin
          err = 1'b1;
        end else begin
          sub_count_next = cs + 3'd1;
        end
      end
      default: begin
      end
    endcase

    if (err) begin
      phase_next       = PH_ERROR;
      result.event_res = EV_ERROR;
    end
    result.method = (phase_next == PH_METHOD) ? METHOD_UNKNOWN : method_guess_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_METHOD;
      sub_count      <= '0;
      method_guess   <= METHOD_UNKNOWN;
      store_position <= '0;
      pair_count     <= '0;
      in_key         <= 1'b1;
      escape_stage   <= '0;
      high_nibble    <= '0;
      major_digit    <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      sub_count      <= sub_count_next;
      method_guess   <= method_guess_next;
      store_position <= store_position_next;
      pair_count     <= pair_count_next;
      in_key         <= in_key_next;
      escape_stage   <= escape_stage_next;
      high_nibble    <= high_nibble_next;
      major_digit    <= major_digit_next;
    end
  end

endmodule

// File: rtl/hrlp_out_reg.sv
// Result register of the parser output stream with its valid flag.
// Depends on hrlp_pkg.
module hrlp_out_reg
  import hrlp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result,
  input  logic    m_tready,
  output logic    m_tvalid,
  output result_t held,
  output logic    free
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

// File: rtl/http_request_line_parser.sv
// Top level of the HTTP request line parser: byte stream in, event stream out.
// Depends on hrlp_pkg, hrlp_core and hrlp_out_reg.
//
// The slave channel takes one raw byte of the request line per beat; tuser
// set marks the first byte of a new request and clears the parser first.
// The master channel gives exactly one event beat for every byte taken:
// path, query key or value bytes, a new query pair, line complete with the
// version digits, an error, or no event.
// An accepted byte gives its event beat in the next cycle. One byte can be
// taken every cycle while the receiver keeps up; the parser state update per
// byte sits between the state registers and the result register.
// A byte is taken whenever the result register is empty or its beat is being
// taken in the same cycle, so a stalled receiver holds the input off after
// one outstanding beat.
// Synchronous reset returns the parser to method matching and empties the
// result register.
module http_request_line_parser
  import hrlp_pkg::*;
#(
  parameter int MAX_PATH    = 256,
  parameter int MAX_QUERIES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,  // byte_value
  input  logic               s_tuser,  // restart
  output logic               m_tvalid,
  input  logic               m_tready,
  // data[7:0], method[10:8], path_position[18:11], query_index[23:19],
  // version_major[32:24], version_minor[41:33], zero fill[47:42]
  output logic [TDATA_W-1:0] m_tdata,
  output logic [2:0]         m_tuser   // event_res
);

  logic    accept;
  result_t result;
  result_t held;

  assign accept = s_tvalid && s_tready;

  hrlp_core #(
    .MAX_PATH    (MAX_PATH),
    .MAX_QUERIES (MAX_QUERIES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_value (s_tdata),
    .restart    (s_tuser),
    .result     (result)
  );

  hrlp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .result   (result),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .held     (held),
    .free     (s_tready)
  );

  assign m_tuser = held.event_res;
  assign m_tdata = {6'd0, held.version_minor, held.version_major, held.query_index,
                    held.path_position, held.method, held.data};

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted byte produced no result beat");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= EV_ERROR)
    else $error("event code out of range");

  a_complete_method: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == EV_COMPLETE |-> m_tdata[10:8] != METHOD_UNKNOWN)
    else $error("line completed without a matched method");
`endif

endmodule

// File: test/tb_http_request_line_parser.sv
// Self-checking testbench for http_request_line_parser: a directed request line, then random
// request lines fed byte by byte, each event beat checked against a scripted result or an in-bench parser model.
// Depends on hrlp_pkg and the RTL of the block; reads no files.
module tb_http_request_line_parser;
  import hrlp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PATH     = 256;
  localparam int MAX_QUERIES  = 32;
  localparam int RANDOM_BYTES = 1250;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_OFF     = 300;

  localparam int SHAPE_PLAIN      = 0;
  localparam int SHAPE_LONG_PATH  = 1;
  localparam int SHAPE_MANY_PAIRS = 2;
  localparam int SHAPE_NOISE      = 3;

  localparam string PATH_SAFE =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789/-._~";
  localparam string PATH_PUNCT   = "/-._~";
  localparam string HEX_CHARS    = "0123456789abcdefABCDEF";
  localparam string DIGITS       = "0123456789";
  localparam string VERSION_TEXT = "HTTP/?.";

  localparam result_t QUIET = '0;

  typedef struct packed {
    logic [7:0] b;
    logic       restart;
    logic       typed;
    result_t    want;
  } script_row_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic [2:0]          m_tuser;

  string method_word [6] = '{"", "GET ", "PUT ", "POST ", "PATCH ", "DELETE "};

  // A GET line with an escape, a query and extreme version bytes, then bad methods.
  script_row_t script [26] = '{
    '{"G", 1'b1, 1'b1, QUIET},
    '{"E", 1'b0, 1'b0, QUIET},
    '{"T", 1'b0, 1'b0, QUIET},
    '{" ", 1'b0, 1'b1, '{EV_NONE, 8'h00, METHOD_GET, 8'd0, 5'd0, 9'sd0, 9'sd0}},
    '{"/", 1'b0, 1'b1, '{EV_PATH, "/", METHOD_GET, 8'd0, 5'd0, 9'sd0, 9'sd0}},
    '{"%", 1'b0, 1'b0, QUIET},
    '{"f", 1'b0, 1'b0, QUIET},
    '{"F", 1'b0, 1'b1, '{EV_PATH, 8'hFF, METHOD_GET, 8'd1, 5'd0, 9'sd0, 9'sd0}},
    '{"?", 1'b0, 1'b1, '{EV_NEW_PAIR, 8'h00, METHOD_GET, 8'd0, 5'd0, 9'sd0, 9'sd0}},
    '{"k", 1'b0, 1'b0, QUIET},
    '{"=", 1'b0, 1'b0, QUIET},
    '{8'hFF, 1'b0, 1'b0, QUIET},
    '{"&", 1'b0, 1'b1, '{EV_NEW_PAIR, 8'h00, METHOD_GET, 8'd0, 5'd1, 9'sd0, 9'sd0}},
    '{" ", 1'b0, 1'b0, QUIET},
    '{"H", 1'b0, 1'b0, QUIET},
    '{"T", 1'b0, 1'b0, QUIET},
    '{"T", 1'b0, 1'b0, QUIET},
    '{"P", 1'b0, 1'b0, QUIET},
    '{"/", 1'b0, 1'b0, QUIET},
    '{8'h00, 1'b0, 1'b0, QUIET},
    '{".", 1'b0, 1'b0, QUIET},
    '{8'hFF, 1'b0, 1'b1, '{EV_COMPLETE, 8'h00, METHOD_GET, 8'd0, 5'd0, -9'sd48, 9'sd207}},
    '{"Z", 1'b0, 1'b1, '{EV_NONE, 8'h00, METHOD_GET, 8'd0, 5'd0, 9'sd0, 9'sd0}},
    '{"Q", 1'b1, 1'b1, '{EV_ERROR, 8'h00, METHOD_UNKNOWN, 8'd0, 5'd0, 9'sd0, 9'sd0}},
    '{"P", 1'b1, 1'b0, QUIET},
    '{"X", 1'b0, 1'b1, '{EV_ERROR, 8'h00, METHOD_UNKNOWN, 8'd0, 5'd0, 9'sd0, 9'sd0}}
  };

  phase_t     ph         = PH_METHOD;
  int         sub_idx    = 0;
  logic [2:0] guess      = METHOD_UNKNOWN;
  int         store_pos  = 0;
  int         pair_total = 0;
  logic       key_side   = 1'b1;
  logic [1:0] esc_stage  = 2'd0;
  logic [7:0] high_nib   = 8'h00;
  logic [8:0] major_val  = 9'd0;

  result_t    expected_results [$];
  logic [7:0] line_bytes [$];

  int   failures      = 0;
  int   beats_seen    = 0;
  int   bytes_taken   = 0;
  int   cycle_count   = 0;
  int   hold_cycles   = 0;
  int   event_seen [8];
  logic pressure_done = 1'b0;
  logic sender_steady = 1'b0;

  http_request_line_parser #(
    .MAX_PATH    (MAX_PATH),
    .MAX_QUERIES (MAX_QUERIES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] hex_digit(input logic [7:0] b);
    logic [7:0] u;
    u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    return u - ((u >= "A") ? 8'd55 : 8'd48);
  endfunction

  function automatic logic path_byte_ok(input logic [7:0] b);
    logic [7:0] folded;
    logic       ok;
    int         i;
    folded = b | 8'h20;
    ok = (b >= "0" && b <= "9") || (folded >= "a" && folded <= "z");
    for (i = 0; i < PATH_PUNCT.len(); i++) begin
      if (b == PATH_PUNCT[i]) begin
        ok = 1'b1;
      end
    end
    return ok;
  endfunction

  // Advances the parser model by one byte and returns the event beat it should give.
  function automatic result_t parse_byte(input logic [7:0] b, input logic restart);
    result_t    r;
    logic       bad;
    logic       emit;
    logic       in_query;
    logic [7:0] val;
    logic [7:0] lo;
    r = QUIET;
    bad = 1'b0;
    emit = 1'b0;
    val = 8'h00;
    if (restart) begin
      ph = PH_METHOD;
      sub_idx = 0;
      guess = METHOD_UNKNOWN;
      store_pos = 0;
      pair_total = 0;
      key_side = 1'b1;
      esc_stage = 2'd0;
      high_nib = 8'h00;
      major_val = 9'd0;
    end
    case (ph)
      PH_METHOD: begin
        if (sub_idx == 0) begin
          case (b)
            "G":     guess = METHOD_GET;
            "P":     guess = METHOD_PUT;
            "D":     guess = METHOD_DELETE;
            default: bad = 1'b1;
          endcase
        end else if (sub_idx == 1 && guess >= METHOD_PUT && guess <= METHOD_PATCH) begin
          case (b)
            "U":     guess = METHOD_PUT;
            "O":     guess = METHOD_POST;
            "A":     guess = METHOD_PATCH;
            default: bad = 1'b1;
          endcase
        end else if (sub_idx >= method_word[guess].len() ||
                     b != method_word[guess][sub_idx]) begin
          bad = 1'b1;
        end
        if (bad) begin
          guess = METHOD_UNKNOWN;
        end else if (sub_idx + 1 == method_word[guess].len()) begin
          ph = PH_PATH;
          sub_idx = 0;
        end else begin
          sub_idx++;
        end
      end
      PH_PATH, PH_QUERY: begin
        in_query = (ph == PH_QUERY);
        if (esc_stage == 2'd1) begin
          high_nib = hex_digit(b);
          esc_stage = 2'd2;
        end else if (esc_stage == 2'd2) begin
          esc_stage = 2'd0;
          lo = hex_digit(b);
          val = {high_nib[3:0], 4'h0} | lo;
          emit = 1'b1;
        end else if (store_pos >= (in_query ? MAX_PATH : MAX_PATH - 1)) begin
          bad = 1'b1;
        end else if (b == " ") begin
          ph = PH_VERSION;
          sub_idx = 0;
        end else if (b == 8'h00) begin
          bad = 1'b1;
        end else if (!in_query && b == "?") begin
          ph = PH_QUERY;
          store_pos++;
          pair_total = 1;
          key_side = 1'b1;
          r.event_res = EV_NEW_PAIR;
        end else if (in_query && b == "=" && key_side) begin
          key_side = 1'b0;
          store_pos++;
        end else if (in_query && b == "&") begin
          if (pair_total >= MAX_QUERIES) begin
            bad = 1'b1;
          end else begin
            pair_total++;
            key_side = 1'b1;
            store_pos++;
            r.event_res = EV_NEW_PAIR;
            r.query_index = 5'(pair_total - 1);
          end
        end else if (b == "%") begin
          esc_stage = 2'd1;
        end else if (!in_query && !path_byte_ok(b)) begin
          bad = 1'b1;
        end else begin
          val = b;
          emit = 1'b1;
        end
        if (emit) begin
          r.event_res = in_query ? (key_side ? EV_KEY : EV_VALUE) : EV_PATH;
          r.data = val;
          r.path_position = 8'(store_pos);
          if (in_query) begin
            r.query_index = 5'(pair_total - 1);
          end
          store_pos++;
        end
      end
      PH_VERSION: begin
        if (sub_idx == 5) begin
          major_val = {1'b0, b} - 9'd48;
          sub_idx++;
        end else if (sub_idx == 7) begin
          r.event_res = EV_COMPLETE;
          r.version_major = major_val;
          r.version_minor = {1'b0, b} - 9'd48;
          ph = PH_DONE;
        end else if (b != VERSION_TEXT[sub_idx]) begin
          bad = 1'b1;
        end else begin
          sub_idx++;
        end
      end
      default: begin
      end
    endcase
    if (bad) begin
      ph = PH_ERROR;
      r.event_res = EV_ERROR;
    end
    r.method = (ph == PH_METHOD) ? METHOD_UNKNOWN : guess;
    return r;
  endfunction

  function automatic logic [7:0] pick_from(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void push_escape();
    int i;
    line_bytes.push_back("%");
    for (i = 0; i < 2; i++) begin
      line_bytes.push_back(($urandom_range(0, 9) < 7) ? pick_from(HEX_CHARS) : 8'($urandom));
    end
  endfunction

  function automatic void push_query_byte();
    int         r;
    logic [7:0] v;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      push_escape();
    end else if (r == 1) begin
      do begin
        v = 8'($urandom);
      end while (v == 8'h00 || v == " " || v == "&");
      line_bytes.push_back(v);
    end else begin
      line_bytes.push_back(pick_from(PATH_SAFE));
    end
  endfunction

  function automatic void make_request(input int shape);
    int m;
    int i;
    int plen;
    int pairs;
    int cut;
    line_bytes.delete();
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 8)) begin
        line_bytes.push_back(8'($urandom));
      end
      return;
    end
    m = $urandom_range(METHOD_GET, METHOD_DELETE);
    for (i = 0; i < method_word[m].len(); i++) begin
      line_bytes.push_back(method_word[m][i]);
    end
    line_bytes.push_back("/");
    plen = (shape == SHAPE_LONG_PATH) ? $urandom_range(235, 262) : $urandom_range(0, 12);
    repeat (plen) begin
      if ($urandom_range(0, 19) == 0) begin
        push_escape();
      end else begin
        line_bytes.push_back(pick_from(PATH_SAFE));
      end
    end
    if (shape == SHAPE_MANY_PAIRS) begin
      pairs = $urandom_range(31, 34);
    end else begin
      pairs = $urandom_range(0, 1) ? $urandom_range(1, 4) : 0;
    end
    for (i = 0; i < pairs; i++) begin
      line_bytes.push_back((i == 0) ? 8'("?") : 8'("&"));
      repeat ($urandom_range(0, (shape == SHAPE_MANY_PAIRS) ? 1 : 3)) begin
        push_query_byte();
      end
      if ($urandom_range(0, 4) != 0) begin
        line_bytes.push_back("=");
        repeat ($urandom_range(0, (shape == SHAPE_MANY_PAIRS) ? 2 : 4)) begin
          push_query_byte();
        end
      end
    end
    line_bytes.push_back(" ");
    for (i = 0; i < 5; i++) begin
      line_bytes.push_back(VERSION_TEXT[i]);
    end
    line_bytes.push_back(($urandom_range(0, 3) != 0) ? pick_from(DIGITS) : 8'($urandom));
    line_bytes.push_back(".");
    line_bytes.push_back(($urandom_range(0, 3) != 0) ? pick_from(DIGITS) : 8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom);
    end
    if ($urandom_range(0, 15) == 0) begin
      cut = $urandom_range(1, line_bytes.size());
      while (line_bytes.size() > cut) begin
        void'(line_bytes.pop_back());
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_steady || r < 60) begin
      return 0;
    end
    return (r < 90) ? $urandom_range(1, 3) : (r < 98) ? $urandom_range(4, 12) :
           $urandom_range(20, 40);
  endfunction

  task automatic report_failure(input string msg);
    failures++;
    $display("[%0t] %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
    if (got !== want) begin
      report_failure($sformatf("beat %0d: %s is %0h, expected %0h", beats_seen, name, got,
                               want));
    end
  endtask

  task automatic feed_byte(input logic [7:0] b, input logic restart, input logic typed,
                           input result_t want);
    int      gap;
    result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= restart;
    do begin
      @(posedge clk);
    end while (!s_tready);
    bytes_taken++;
    predicted = parse_byte(b, restart);
    expected_results.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      beats_seen++;
      event_seen[m_tuser]++;
      if (expected_results.size() == 0) begin
        report_failure($sformatf("beat %0d arrived with nothing expected", beats_seen));
      end else begin
        want = expected_results.pop_front();
        check_field("event", m_tuser, want.event_res);
        check_field("data", m_tdata[7:0], want.data);
        check_field("method", m_tdata[10:8], want.method);
        check_field("path_position", m_tdata[18:11], want.path_position);
        check_field("query_index", m_tdata[23:19], want.query_index);
        check_field("version_major", m_tdata[32:24], want.version_major);
        check_field("version_minor", m_tdata[41:33], want.version_minor);
      end
    end
  end

  initial begin : receiver
    int r;
    int run;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (!pressure_done && bytes_taken >= 400) begin
        m_tready <= 1'b0;
        while (hold_cycles < HOLD_OFF) begin
          @(posedge clk);
          hold_cycles++;
        end
        pressure_done = 1'b1;
      end
      r = $urandom_range(0, 9);
      run = (r == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      r = $urandom_range(0, 99);
      stall = (r < 45) ? 0 : (r < 85) ? $urandom_range(1, 3) :
              (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 40);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d beats outstanding", cycle_count,
             expected_results.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int r;
    int shape;
    int req_no;
    int counted;
    int lines_sent;
    counted = 0;
    lines_sent = 0;
    req_no = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (script[i]) begin
      feed_byte(script[i].b, script[i].restart, script[i].typed, script[i].want);
    end
    while (counted < RANDOM_BYTES) begin
      case (req_no)
        2: shape = SHAPE_LONG_PATH;
        4: shape = SHAPE_MANY_PAIRS;
        default: begin
          r = $urandom_range(0, 99);
          shape = (r < 6) ? SHAPE_LONG_PATH : (r < 12) ? SHAPE_MANY_PAIRS :
                  (r < 22) ? SHAPE_NOISE : SHAPE_PLAIN;
        end
      endcase
      make_request(shape);
      sender_steady = ($urandom_range(0, 4) == 0);
      foreach (line_bytes[i]) begin
        feed_byte(line_bytes[i], i == 0, 1'b0, QUIET);
      end
      counted += line_bytes.size();
      lines_sent++;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          feed_byte(8'($urandom), 1'b0, 1'b0, QUIET);
        end
      end
      req_no++;
    end
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Fed %0d bytes in %0d random lines; beats carried %0d path, %0d key, %0d value",
             bytes_taken, lines_sent, event_seen[EV_PATH], event_seen[EV_KEY],
             event_seen[EV_VALUE]);
    $display("bytes, %0d new pairs, %0d finished lines and %0d errors; receiver held %0d cycles",
             event_seen[EV_NEW_PAIR], event_seen[EV_COMPLETE], event_seen[EV_ERROR],
             hold_cycles);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
